### hdl/qnlerp_pkg.sv
// shared widths and types for the quaternion nlerp normalizer
package qnlerp_pkg;
  localparam int CompW = 16;
  localparam int WFracW = 16;
  localparam int WeightW = WFracW + 1;
  localparam int OutFrac = CompW - 2;
  localparam int BlendW = CompW + 2;
  localparam int MagW = CompW + 1;
  localparam int SumW = 2 * MagW + 2;
  localparam int RootW = SumW / 2;
  localparam int NumW = MagW + OutFrac;
  localparam int QueueDepth = 8;
  localparam int QueueAw = 3;

  typedef logic signed [BlendW-1:0] blend_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [3:0]           neg;
    logic [3:0][MagW-1:0] mag;
    logic [SumW-1:0]      sumsq;
  } fwd_item_t;

  typedef struct packed {
    logic signed [CompW-1:0] w;
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
    logic                    zero_length;
  } res_item_t;
endpackage

### hdl/qnlerp_front.sv
// front part: dot product, path flip, blend and sum of squares, 4 stages
module qnlerp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [3:0][qnlerp_pkg::CompW-1:0] a_in,
  input  logic signed [3:0][qnlerp_pkg::CompW-1:0] b_in,
  input  logic [qnlerp_pkg::WeightW-1:0] t_in,
  output logic                          out_vld,
  output qnlerp_pkg::fwd_item_t         out_item
);
  import qnlerp_pkg::*;

  localparam int ProdW = 2 * CompW;
  localparam int DotW = ProdW + 2;
  localparam int DiffW = CompW + 2;
  localparam int TProdW = DiffW + WeightW + 1;

  logic [3:0] vld_r;
  // stage 1: products of a and b
  logic signed [3:0][CompW-1:0] a1_r, b1_r;
  logic signed [3:0][ProdW-1:0] p1_r;
  logic [WeightW-1:0] t1_r;
  // stage 2: difference after flip
  logic signed [3:0][CompW-1:0] a2_r;
  logic signed [3:0][DiffW-1:0] d2_r;
  logic [WeightW-1:0] t2_r;
  // stage 3: blend
  logic signed [3:0][BlendW-1:0] c3_r;
  // stage 4: magnitudes and sum
  logic [3:0] neg4_r;
  logic [3:0][MagW-1:0] mag4_r;
  logic [SumW-1:0] sum4_r;

  logic signed [DotW-1:0] dot;
  logic signed [3:0][TProdW-1:0] tp;
  logic [3:0] neg_c;
  logic [3:0][MagW-1:0] mag_c;
  logic [SumW-1:0] sum_c;

  always_comb begin
    dot = '0;
    for (int i = 0; i < 4; i++) dot = dot + DotW'($signed(p1_r[i]));
    for (int i = 0; i < 4; i++) begin
      tp[i] = $signed({1'b0, t2_r}) * $signed(d2_r[i]);
    end
    sum_c = '0;
    for (int i = 0; i < 4; i++) begin
      neg_c[i] = c3_r[i][BlendW-1];
      mag_c[i] = neg_c[i] ? MagW'(-c3_r[i]) : MagW'(c3_r[i]);
      sum_c = sum_c + SumW'(mag_c[i]) * SumW'(mag_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
    if (en) begin
      a1_r <= a_in;
      b1_r <= b_in;
      t1_r <= (t_in > WeightW'(1 << WFracW)) ? WeightW'(1 << WFracW) : t_in;
      for (int i = 0; i < 4; i++) p1_r[i] <= $signed(a_in[i]) * $signed(b_in[i]);
      a2_r <= a1_r;
      t2_r <= t1_r;
      for (int i = 0; i < 4; i++) begin
        d2_r[i] <= dot[DotW-1] ? -DiffW'($signed(b1_r[i])) - DiffW'($signed(a1_r[i]))
                               : DiffW'($signed(b1_r[i])) - DiffW'($signed(a1_r[i]));
      end
      for (int i = 0; i < 4; i++) begin
        c3_r[i] <= BlendW'($signed(a2_r[i])) + BlendW'($signed(tp[i]) >>> WFracW);
      end
      neg4_r <= neg_c;
      mag4_r <= mag_c;
      sum4_r <= sum_c;
    end
  end

  assign out_vld = vld_r[3];
  assign out_item.neg = neg4_r;
  assign out_item.mag = mag4_r;
  assign out_item.sumsq = sum4_r;
endmodule

### hdl/qnlerp_queue.sv
// small fifo between front and back
module qnlerp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  qnlerp_pkg::fwd_item_t wr_item,
  input  logic                  rd_en,
  output qnlerp_pkg::fwd_item_t rd_item,
  output logic                  rd_vld,
  output logic [qnlerp_pkg::QueueAw:0] count
);
  import qnlerp_pkg::*;

  fwd_item_t mem_r [QueueDepth];
  logic [QueueAw-1:0] wp_r, rp_r;
  logic [QueueAw:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QueueAw+1)'(wr_en) - (QueueAw+1)'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

  assign rd_item = mem_r[rp_r];
  assign rd_vld = cnt_r != '0;
  assign count = cnt_r;
endmodule

### hdl/qnlerp_back.sv
// back part: pipelined square root then pipelined division of each component
module qnlerp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  qnlerp_pkg::fwd_item_t in_item,
  output logic                  out_vld,
  output qnlerp_pkg::res_item_t out_item
);
  import qnlerp_pkg::*;

  // one root bit per stage, then one quotient bit per stage
  localparam int SqSt = RootW;
  localparam int DivSt = NumW;
  localparam int Lat = SqSt + DivSt;
  localparam int RemW = RootW + 2;

  logic [Lat-1:0] vld_r;
  logic [SqSt:1][3:0] sneg_r;
  logic [SqSt:1][3:0][MagW-1:0] smag_r;
  logic [SqSt:1][SumW-1:0] srem_r;
  logic [SqSt:1][RootW-1:0] sroot_r;

  logic [DivSt:1][3:0] dneg_r;
  logic [DivSt:1][RootW-1:0] dlen_r;
  logic [DivSt:1][3:0][NumW-1:0] dnum_r;
  logic [DivSt:1][3:0][RemW-1:0] drem_r;
  logic [DivSt:1][3:0][NumW-1:0] dq_r;

  genvar g;
  generate
    for (g = 0; g < SqSt; g++) begin : g_sq
      localparam int B = SqSt - 1 - g;
      logic [3:0] neg_s;
      logic [3:0][MagW-1:0] mag_s;
      logic [SumW-1:0] rem_s;
      logic [RootW-1:0] root_s;
      logic [RootW-1:0] trial;
      logic [SumW-1:0] tsq;
      if (g == 0) begin : g_load
        assign neg_s = in_item.neg;
        assign mag_s = in_item.mag;
        assign rem_s = in_item.sumsq;
        assign root_s = '0;
      end else begin : g_link
        assign neg_s = sneg_r[g];
        assign mag_s = smag_r[g];
        assign rem_s = srem_r[g];
        assign root_s = sroot_r[g];
      end
      always_comb begin
        trial = root_s | (RootW'(1) << B);
        tsq = SumW'(trial) * SumW'(trial);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sneg_r[g+1] <= neg_s;
          smag_r[g+1] <= mag_s;
          srem_r[g+1] <= rem_s;
          sroot_r[g+1] <= (tsq <= rem_s) ? trial : root_s;
        end
      end
    end

    for (g = 0; g < DivSt; g++) begin : g_div
      localparam int B = DivSt - 1 - g;
      logic [3:0] neg_s;
      logic [RootW-1:0] len_s;
      logic [3:0][NumW-1:0] num_s;
      logic [3:0][RemW-1:0] rem_s;
      logic [3:0][NumW-1:0] q_s;
      logic [3:0][RemW-1:0] sh;
      if (g == 0) begin : g_load
        assign neg_s = sneg_r[SqSt];
        assign len_s = sroot_r[SqSt];
        assign rem_s = '0;
        assign q_s = '0;
        always_comb begin
          for (int i = 0; i < 4; i++) num_s[i] = NumW'(smag_r[SqSt][i]) << OutFrac;
        end
      end else begin : g_link
        assign neg_s = dneg_r[g];
        assign len_s = dlen_r[g];
        assign num_s = dnum_r[g];
        assign rem_s = drem_r[g];
        assign q_s = dq_r[g];
      end
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          sh[i] = {rem_s[i][RemW-2:0], num_s[i][B]};
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dneg_r[g+1] <= neg_s;
          dlen_r[g+1] <= len_s;
          dnum_r[g+1] <= num_s;
          for (int i = 0; i < 4; i++) begin
            if (sh[i] >= RemW'(len_s)) begin
              drem_r[g+1][i] <= sh[i] - RemW'(len_s);
              dq_r[g+1][i] <= q_s[i] | (NumW'(1) << B);
            end else begin
              drem_r[g+1][i] <= sh[i];
              dq_r[g+1][i] <= q_s[i];
            end
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_vld};
    end
  end

  logic [3:0][CompW-1:0] sat;
  logic zl;
  always_comb begin
    zl = dlen_r[DivSt] == '0;
    for (int i = 0; i < 4; i++) begin
      logic [CompW-1:0] q;
      q = (dq_r[DivSt][i] > NumW'(1 << OutFrac)) ? CompW'(1 << OutFrac)
                                                 : CompW'(dq_r[DivSt][i]);
      sat[i] = dneg_r[DivSt][i] ? -q : q;
    end
    if (zl) begin
      sat[0] = CompW'(1 << OutFrac);
      sat[1] = '0;
      sat[2] = '0;
      sat[3] = '0;
    end
  end

  assign out_vld = vld_r[Lat-1];
  assign out_item.w = sat[0];
  assign out_item.x = sat[1];
  assign out_item.y = sat[2];
  assign out_item.z = sat[3];
  assign out_item.zero_length = zl;
endmodule

### hdl/quaternion_nlerp_normalize.sv
// top level of the quaternion nlerp normalizer
// Usage:
// - input channel in_valid/in_ready carries two Q1.14 quaternions and a
//   Q1.16 weight; the result channel out_valid/out_ready carries a Q1.14
//   unit quaternion and a zero_length flag (identity when the blend is zero).
// - one item is accepted per cycle while the block has room.
// - pipeline: 4 front stages, the queue, 18 square root stages and
//   31 division stages, then the output register.
// - the back pipeline and the output register advance only when the output
//   register is free or being taken, so a stalled receiver freezes them;
//   the front keeps feeding the 8-entry queue and in_ready drops once the
//   queue cannot absorb the items still in the front.
// - reset (rst_n low, synchronous) empties the pipelines and the queue;
//   no item is lost or repeated across a stall.
module quaternion_nlerp_normalize (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_a_w,
  input  logic signed [15:0] in_a_x,
  input  logic signed [15:0] in_a_y,
  input  logic signed [15:0] in_a_z,
  input  logic signed [15:0] in_b_w,
  input  logic signed [15:0] in_b_x,
  input  logic signed [15:0] in_b_y,
  input  logic signed [15:0] in_b_z,
  input  logic [16:0] in_t_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic        out_zero_length
);
  import qnlerp_pkg::*;

  logic f_vld, q_vld, b_vld, b_en, q_rd;
  fwd_item_t f_item, q_item;
  res_item_t b_item, res_r;
  logic res_vld_r;
  logic [QueueAw:0] q_cnt;
  logic [3:0] f_pipe_cnt_r;
  logic [3:0] accepted_s;

  // back advances when the output slot is free or being taken; pulls from queue at the same time
  assign b_en = !res_vld_r || out_ready;
  assign q_rd = b_en && q_vld;

  // the front always advances; only admit an item if the queue has room for
  // everything already in flight in the front
  assign accepted_s = 4'(in_valid && in_ready);
  assign in_ready = (5'(q_cnt) + 5'(f_pipe_cnt_r)) < 5'(QueueDepth);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_pipe_cnt_r <= '0;
    end else begin
      f_pipe_cnt_r <= f_pipe_cnt_r + accepted_s - 4'(f_vld);
    end
  end

  qnlerp_front u_front (
    .clk, .rst_n, .en(1'b1), .in_vld(in_valid && in_ready),
    .a_in({in_a_z, in_a_y, in_a_x, in_a_w}),
    .b_in({in_b_z, in_b_y, in_b_x, in_b_w}),
    .t_in(in_t_weight), .out_vld(f_vld), .out_item(f_item)
  );

  qnlerp_queue u_queue (
    .clk, .rst_n, .wr_en(f_vld), .wr_item(f_item), .rd_en(q_rd),
    .rd_item(q_item), .rd_vld(q_vld), .count(q_cnt)
  );

  qnlerp_back u_back (
    .clk, .rst_n, .en(b_en), .in_vld(q_rd), .in_item(q_item),
    .out_vld(b_vld), .out_item(b_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (b_en) begin
      res_vld_r <= b_vld;
    end
    if (b_en) res_r <= b_item;
  end

  assign out_valid = res_vld_r;
  assign out_w = res_r.w;
  assign out_x = res_r.x;
  assign out_y = res_r.y;
  assign out_z = res_r.z;
  assign out_zero_length = res_r.zero_length;
endmodule

### tb/sv/testbench.sv
// self-checking testbench for the quaternion nlerp normalizer
module testbench;
  import qnlerp_pkg::*;

  localparam int LatencyCycles = 60;
  localparam int StallLimit = 5000;
  localparam int RandomItems = 2000;

  typedef struct {
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    logic [16:0]        t;
  } pair_item_t;

  // integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic res_item_t blend_normalize(pair_item_t it);
    res_item_t r;
    longint dotp;
    longint c [4];
    longint bb;
    longint prod;
    longint unsigned t;
    longint unsigned mag;
    longint unsigned sumsq;
    longint unsigned len;
    longint unsigned q;
    longint v [4];
    dotp = 0;
    sumsq = 0;
    t = it.t > 17'd65536 ? 65536 : it.t;
    for (int i = 0; i < 4; i++) dotp += longint'(it.a[i]) * longint'(it.b[i]);
    for (int i = 0; i < 4; i++) begin
      bb = dotp < 0 ? -longint'(it.b[i]) : longint'(it.b[i]);
      prod = longint'(t) * (bb - longint'(it.a[i]));
      // arithmetic shift is a floor divide
      c[i] = longint'(it.a[i]) + (prod >>> 16);
      mag = c[i] < 0 ? -c[i] : c[i];
      sumsq += mag * mag;
    end
    len = root_floor(sumsq);
    if (len == 0) begin
      r.w = 16384; r.x = 0; r.y = 0; r.z = 0; r.zero_length = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      mag = c[i] < 0 ? -c[i] : c[i];
      q = (mag << 14) / len;
      if (q > 16384) q = 16384;
      v[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    r.w = v[0][15:0]; r.x = v[1][15:0]; r.y = v[2][15:0]; r.z = v[3][15:0];
    r.zero_length = 1'b0;
    return r;
  endfunction

  class nlerp_scoreboard;
    res_item_t pending[$];
    int errors;
    function void note_item(res_item_t e);
      pending.push_back(e);
    endfunction
    function void check_result(res_item_t got);
      res_item_t e;
      if (pending.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.w !== e.w) begin
        $error("out_w expected %0d got %0d", e.w, got.w); errors++;
      end
      if (got.x !== e.x) begin
        $error("out_x expected %0d got %0d", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $error("out_y expected %0d got %0d", e.y, got.y); errors++;
      end
      if (got.z !== e.z) begin
        $error("out_z expected %0d got %0d", e.z, got.z); errors++;
      end
      if (got.zero_length !== e.zero_length) begin
        $error("out_zero_length expected %0d got %0d", e.zero_length, got.zero_length);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_a_w = 0, in_a_x = 0, in_a_y = 0, in_a_z = 0;
  logic signed [15:0] in_b_w = 0, in_b_x = 0, in_b_y = 0, in_b_z = 0;
  logic [16:0] in_t_weight = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] out_w, out_x, out_y, out_z;
  logic out_zero_length;

  quaternion_nlerp_normalize dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_w(in_a_w), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_w(in_b_w), .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_t_weight(in_t_weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_zero_length(out_zero_length)
  );

  nlerp_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // accepted items and results are seen at the edge
  always @(posedge clk) begin
    pair_item_t it;
    res_item_t got;
    if (rst_n && in_valid && in_ready) begin
      it.a = '{in_a_w, in_a_x, in_a_y, in_a_z};
      it.b = '{in_b_w, in_b_x, in_b_y, in_b_z};
      it.t = in_t_weight;
      board.note_item(blend_normalize(it));
    end
    if (rst_n && out_valid && out_ready) begin
      got.w = out_w; got.x = out_x; got.y = out_y; got.z = out_z;
      got.zero_length = out_zero_length;
      board.check_result(got);
    end
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= StallLimit) begin
      $display("quaternion_nlerp_normalize test failed");
      $finish;
    end
  end

  // receiver ready, random stalls or a long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(pair_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_w <= it.a[0]; in_a_x <= it.a[1]; in_a_y <= it.a[2]; in_a_z <= it.a[3];
    in_b_w <= it.b[0]; in_b_x <= it.b[1]; in_b_y <= it.b[2]; in_b_z <= it.b[3];
    in_t_weight <= it.t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 4)) - 16'd2;
      3: return 16'($urandom_range(0, 32768)) - 16'd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pair_item_t rand_item();
    pair_item_t it;
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      it.a[i] = rand_comp();
      it.b[i] = rand_comp();
    end
    // plain normalizer, opposite pair and zero pair
    if (kind == 0) it.b = it.a;
    if (kind == 1) for (int i = 0; i < 4; i++) it.b[i] = -it.a[i];
    if (kind == 2) begin
      it.a = '{0, 0, 0, 0};
      it.b = '{0, 0, 0, 0};
    end
    case ($urandom_range(5))
      0: it.t = 0;
      1: it.t = 65536;
      2: it.t = 17'($urandom_range(65537, 131071));
      default: it.t = 17'($urandom);
    endcase
    if (kind == 0 && $urandom_range(1)) it.t = 0;
    return it;
  endfunction

  task automatic send_directed();
    pair_item_t it;
    logic signed [15:0] ext [4];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    for (int k = 0; k < 4; k++) begin
      it.a = '{ext[k], ext[k], ext[k], ext[k]};
      it.b = '{ext[3-k], ext[k], ext[3-k], ext[k]};
      it.t = 17'd65536 >> k;
      send_item(it);
    end
    // zero length gives identity
    it.a = '{0, 0, 0, 0}; it.b = '{0, 0, 0, 0}; it.t = 0; send_item(it);
    // t of one gives b, and an opposite b is flipped so the blend keeps a
    it.a = '{2, 0, 0, 0}; it.b = '{0, 2, 0, 0}; it.t = 17'd65536; send_item(it);
    it.a = '{16384, 0, 0, 0}; it.b = '{-16384, 0, 0, 0}; it.t = 17'd32768;
    send_item(it);
    // zero dot does not flip b
    it.a = '{16384, 0, 0, 0}; it.b = '{0, 16384, 0, 0}; it.t = 17'd32768;
    send_item(it);
    // weight above one saturates
    it.a = '{100, 200, -300, 400}; it.b = '{-5, 6, 7, -8}; it.t = 17'h1ffff;
    send_item(it);
    it.t = 17'd65537; send_item(it);
    // negated -32768 and plain normalize
    it.a = '{1, 1, 1, 1}; it.b = '{-32768, -32768, -32768, -32768}; it.t = 17'd65536;
    send_item(it);
    it.a = '{-32768, 0, 0, 0}; it.b = it.a; it.t = 0; send_item(it);
    it.a = '{1, 0, 0, 0}; it.b = it.a; it.t = 0; send_item(it);
    it.a = '{0, 0, 0, -1}; it.b = '{0, 0, 0, 1}; it.t = 17'd1; send_item(it);
    it.a = '{32767, -32768, 32767, -32768}; it.b = '{-32768, 32767, -32768, 32767};
    it.t = 17'd49152; send_item(it);
    in_valid <= 1'b0;
  endtask

  initial begin
    int per_phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    per_phase = RandomItems / 4;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 38 : 0;
      recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 38 : 0;
      if (ph == 0) begin
        // long receiver hold-off while items keep coming
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int n = 0; n < per_phase; n++) send_item(rand_item());
      in_valid <= 1'b0;
    end
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("quaternion_nlerp_normalize test passed");
    else
      $display("quaternion_nlerp_normalize test failed");
    $finish;
  end
endmodule

### quaternion_nlerp_normalize.f
hdl/qnlerp_pkg.sv
hdl/qnlerp_front.sv
hdl/qnlerp_queue.sv
hdl/qnlerp_back.sv
hdl/quaternion_nlerp_normalize.sv
tb/sv/testbench.sv
